FILE: rtl/first_fit_free_list_allocator_macros.svh
// Assertion macros used by the allocator's top-level RTL file.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FFFLA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define FFFLA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define FFFLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fffla_pkg.sv
// Types, constants and codes shared by the free-list allocator modules.
package fffla_pkg;

	// Sizing of the block table and of the heap arithmetic.
	localparam int MAX_BLOCKS   = 64;
	localparam int ALIGN_BYTES  = 16;	// must be a power of two
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = 32;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int LINK_W       = $clog2(MAX_BLOCKS + 1);
	localparam int STATUS_W     = 3;
	localparam int CFG_IDX_W    = 8;

	localparam logic [LINK_W-1:0] NULL_LINK   = LINK_W'(MAX_BLOCKS);
	localparam logic [LINK_W-1:0] TABLE_FULL  = LINK_W'(MAX_BLOCKS);
	localparam logic [ADDR_W-1:0] HEADER_ADD  = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W:0]   ALIGN_ADD   = (ADDR_W + 1)'(ALIGN_BYTES - 1);
	localparam logic [ADDR_W:0]   ALIGN_MASK  = ~ALIGN_ADD;
	localparam logic [ADDR_W+1:0] HEADER_WIDE = (ADDR_W + 2)'(HEADER_BYTES);

	// Request actions.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 8'd1;

	// Request transaction payload.
	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] request_size;
		logic [ADDR_W-1:0] user_address;
	} req_t;

	// Result transaction payload.
	typedef struct packed {
		logic [ADDR_W-1:0]   granted_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic walk_next;
		logic walk_take;
		logic bump_take;
		logic alloc_fail;
		logic scan_next;
		logic free_take;
		logic free_dup;
		logic free_unknown;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              overflow;
		logic              cur_live;
		logic              fit;
		logic              wall_fail;
		logic              scan_live;
		logic              hit;
		logic              hit_in_use;
		logic              slot_free;
		logic [LINK_W-1:0] head;
		logic [LINK_W-1:0] used;
	} stat_t;

endpackage

FILE: rtl/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list heap allocator.
//
// Each request transaction is handled to completion before the next is taken: an
// allocate walks the free list one entry at a time and may end in a bump carve,
// and a free searches the table entries in order for the user's address. The time
// taken is set by the block table, which has a single read port and is visited one
// entry per cycle, both for the free-list walk and for the address search of a
// free. A finished result sits in an output register, so the next request is
// accepted while it waits. The table needs no clearing after reset; only entries
// below the fill count are ever used. Sizes are rounded to ALIGN_BYTES, which is a
// power of two.
`include "first_fit_free_list_allocator_macros.svh"

module first_fit_free_list_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  fffla_pkg::req_t                 req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output fffla_pkg::rsp_t                 rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fffla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fffla_pkg::ADDR_W-1:0]    cfg_data
);

	fffla_pkg::cmd_t  cmd;
	fffla_pkg::stat_t st;

	// Sequencer for the walk, bump and search steps.
	fffla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.st         (st),
		.req_stall  (req_stall),
		.cmd        (cmd)
	);

	// Block table, pointers and result registers.
	fffla_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A taken request keeps the engine busy in the following cycle.
	`FFFLA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "engine idle right after accepting a request")

	// A new result only appears after the engine has been working on a request.
	`FFFLA_ASSERT_IMPL(a_result_from_work, $rose(rsp_valid), $past(req_stall), "result produced without a request in progress")

	// The free-list head is empty or names a filled table entry.
	`FFFLA_ASSERT_ALWAYS(a_head_in_table, (st.head == fffla_pkg::NULL_LINK) || (st.head < st.used), "free-list head points past the filled table")

endmodule

FILE: rtl/fffla_ctrl.sv
// Controller state machine that sequences allocate and free transactions.
module fffla_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_action,
	input  fffla_pkg::stat_t st,
	output logic            req_stall,
	output fffla_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_BUMP = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Only an idle controller takes a new request.
	assign req_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = (req_action == fffla_pkg::ACT_ALLOC) ? S_WALK : S_SCAN;
				end
			end
			S_WALK: begin
				if (st.overflow) begin
					cmd.alloc_fail = 1'b1;
					state_nxt      = S_DONE;
				end else if (st.cur_live && st.fit) begin
					cmd.walk_take = 1'b1;
					state_nxt     = S_DONE;
				end else if (st.cur_live) begin
					cmd.walk_next = 1'b1;
				end else begin
					state_nxt = S_BUMP;
				end
			end
			S_BUMP: begin
				if (st.wall_fail) begin
					cmd.alloc_fail = 1'b1;
				end else begin
					cmd.bump_take = 1'b1;
				end
				state_nxt = S_DONE;
			end
			S_SCAN: begin
				if (!st.scan_live) begin
					cmd.free_unknown = 1'b1;
					state_nxt        = S_DONE;
				end else if (st.hit) begin
					if (st.hit_in_use) begin
						cmd.free_take = 1'b1;
					end else begin
						cmd.free_dup = 1'b1;
					end
					state_nxt = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_DONE: begin
				if (st.slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: rtl/fffla_datapath.sv
// Datapath: block table memories, free-list pointers, bump pointer and result registers.
module fffla_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fffla_pkg::req_t                   req,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fffla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fffla_pkg::ADDR_W-1:0]      cfg_data,
	input  fffla_pkg::cmd_t                   cmd,
	output fffla_pkg::stat_t                  st,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output fffla_pkg::rsp_t                   rsp
);

	localparam int AW = fffla_pkg::ADDR_W;
	localparam int IW = fffla_pkg::IDX_W;
	localparam int LW = fffla_pkg::LINK_W;

	// Block table: base and size together, link, and in-use flag.
	logic [2*AW-1:0] bb_mem  [fffla_pkg::MAX_BLOCKS];
	logic [LW-1:0]   lnk_mem [fffla_pkg::MAX_BLOCKS];
	logic            use_mem [fffla_pkg::MAX_BLOCKS];

	logic [2*AW-1:0] bb_rd_q;
	logic [LW-1:0]   lnk_rd_q;
	logic            use_rd_q;

	logic [AW-1:0]   heap_start_q;
	logic [AW-1:0]   heap_end_q;
	logic [LW-1:0]   head_q;
	logic [LW-1:0]   used_q;
	logic [AW-1:0]   bump_q;
	logic            started_q;

	logic [LW-1:0]   cur_q;
	logic [LW-1:0]   prev_q;
	logic [LW-1:0]   idx_q;
	logic [AW:0]     rounded_q;
	logic [AW+1:0]   hdr_plus_q;
	logic [AW-1:0]   user_addr_q;

	logic [AW-1:0]   res_addr_q;
	logic [fffla_pkg::STATUS_W-1:0] res_status_q;
	logic            rsp_valid_q;
	fffla_pkg::rsp_t rsp_q;

	logic [AW-1:0]   rd_base;
	logic [AW-1:0]   rd_bytes;
	logic [AW-1:0]   rd_user;
	logic [AW:0]     rounded_in;
	logic [AW+1:0]   bump_end;
	logic [LW-1:0]   idx_next;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            lnk_we;
	logic [IW-1:0]   lnk_waddr;
	logic [LW-1:0]   lnk_wdata;
	logic            use_we;
	logic [IW-1:0]   use_waddr;

	assign rd_base  = bb_rd_q[2*AW-1:AW];
	assign rd_bytes = bb_rd_q[AW-1:0];
	assign rd_user  = rd_base + fffla_pkg::HEADER_ADD;
	assign idx_next = idx_q + LW'(1);

	// Size rounded up to the alignment, one bit wider to catch overflow.
	assign rounded_in = ({1'b0, req.request_size} + fffla_pkg::ALIGN_ADD) & fffla_pkg::ALIGN_MASK;

	// End of a block carved at the bump pointer, formed without wrap.
	assign bump_end = {2'b00, bump_q} + hdr_plus_q;

	// Table read port: primed at accept, then follows the walk or the scan.
	assign rd_en = cmd.accept | cmd.walk_next | cmd.scan_next;
	always_comb begin
		if (cmd.accept) begin
			rd_addr = (req.action == fffla_pkg::ACT_ALLOC) ? head_q[IW-1:0] : '0;
		end else if (cmd.walk_next) begin
			rd_addr = lnk_rd_q[IW-1:0];
		end else begin
			rd_addr = idx_next[IW-1:0];
		end
	end

	// Link write: unlink a taken block from its predecessor, or push a freed one.
	assign lnk_we    = cmd.free_take | (cmd.walk_take & (prev_q != fffla_pkg::NULL_LINK));
	assign lnk_waddr = cmd.free_take ? idx_q[IW-1:0] : prev_q[IW-1:0];
	assign lnk_wdata = cmd.free_take ? head_q : lnk_rd_q;

	// In-use write: set on a grant, cleared on a free.
	assign use_we = cmd.walk_take | cmd.bump_take | cmd.free_take;
	always_comb begin
		if (cmd.walk_take) begin
			use_waddr = cur_q[IW-1:0];
		end else if (cmd.bump_take) begin
			use_waddr = used_q[IW-1:0];
		end else begin
			use_waddr = idx_q[IW-1:0];
		end
	end

	// Table memories with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.bump_take) begin
			bb_mem[used_q[IW-1:0]] <= {bump_q, rounded_q[AW-1:0]};
		end
		if (rd_en) begin
			bb_rd_q <= bb_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_waddr] <= lnk_wdata;
		end
		if (rd_en) begin
			lnk_rd_q <= lnk_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (use_we) begin
			use_mem[use_waddr] <= !cmd.free_take;
		end
		if (rd_en) begin
			use_rd_q <= use_mem[rd_addr];
		end
	end

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= '0;
			heap_end_q   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == fffla_pkg::CFG_HEAP_START) begin
				heap_start_q <= cfg_data;
			end
			if (cfg_index == fffla_pkg::CFG_HEAP_END) begin
				heap_end_q <= cfg_data;
			end
		end
	end

	// Allocator state: free-list head, table fill, bump pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= fffla_pkg::NULL_LINK;
			used_q    <= '0;
			bump_q    <= '0;
			started_q <= 1'b0;
		end else begin
			if (cmd.accept && (req.action == fffla_pkg::ACT_ALLOC) && !started_q) begin
				bump_q    <= heap_start_q;
				started_q <= 1'b1;
			end
			if (cmd.walk_take && (prev_q == fffla_pkg::NULL_LINK)) begin
				head_q <= lnk_rd_q;
			end
			if (cmd.free_take) begin
				head_q <= idx_q;
			end
			if (cmd.bump_take) begin
				used_q <= used_q + LW'(1);
				bump_q <= bump_end[AW-1:0];
			end
		end
	end

	// Per-transaction working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rounded_q   <= rounded_in;
			hdr_plus_q  <= {1'b0, rounded_in} + fffla_pkg::HEADER_WIDE;
			user_addr_q <= req.user_address;
			cur_q       <= head_q;
			prev_q      <= fffla_pkg::NULL_LINK;
			idx_q       <= '0;
		end
		if (cmd.walk_next) begin
			prev_q <= cur_q;
			cur_q  <= lnk_rd_q;
		end
		if (cmd.scan_next) begin
			idx_q <= idx_next;
		end
	end

	// Result of the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.walk_take) begin
			res_addr_q   <= rd_user;
			res_status_q <= fffla_pkg::ST_ALLOCATED;
		end
		if (cmd.bump_take) begin
			res_addr_q   <= bump_q + fffla_pkg::HEADER_ADD;
			res_status_q <= fffla_pkg::ST_ALLOCATED;
		end
		if (cmd.alloc_fail) begin
			res_addr_q   <= '0;
			res_status_q <= fffla_pkg::ST_NO_MEMORY;
		end
		if (cmd.free_take) begin
			res_addr_q   <= '0;
			res_status_q <= fffla_pkg::ST_FREED;
		end
		if (cmd.free_dup) begin
			res_addr_q   <= '0;
			res_status_q <= fffla_pkg::ST_DOUBLE;
		end
		if (cmd.free_unknown) begin
			res_addr_q   <= '0;
			res_status_q <= fffla_pkg::ST_UNKNOWN;
		end
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.granted_address <= res_addr_q;
			rsp_q.status          <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status toward the controller.
	always_comb begin
		st.overflow   = rounded_q[AW];
		st.cur_live   = (cur_q < used_q);
		st.fit        = ({1'b0, rd_bytes} >= rounded_q);
		st.wall_fail  = (bump_end > {2'b00, heap_end_q}) || (used_q == fffla_pkg::TABLE_FULL);
		st.scan_live  = (idx_q < used_q);
		st.hit        = (rd_user == user_addr_q);
		st.hit_in_use = use_rd_q;
		st.slot_free  = !rsp_valid_q || !rsp_stall;
		st.head       = head_q;
		st.used       = used_q;
	end

endmodule
